### hdl/htc_pkg.sv
// Shared types, constants and helper functions for the homogeneous triangle clipper.
// Holds the transaction structs, outcode names and the vertex order tables.
// No dependencies; every other file but htc_fifo imports this package.
`timescale 1ns / 1ps

package htc_pkg;

	// Fixed geometry of the job.
	localparam int PLANE_COUNT    = 6;
	localparam int EMIT_LIMIT     = 8;
	localparam int T_FRAC         = 16;
	localparam int VTX_COMPONENTS = 4;

	typedef logic signed [31:0] q16_t;
	typedef logic [VTX_COMPONENTS-1:0][31:0] vtx_t;   // [0] x, [1] y, [2] z, [3] w
	typedef vtx_t [2:0] tri_t;
	typedef logic signed [32:0] dist_t;
	typedef logic [2:0] plane_t;
	typedef logic [2:0] code_t;
	typedef logic [2:0] src_t;

	localparam plane_t PLANE_LAST = plane_t'(PLANE_COUNT - 1);
	localparam logic [1:0] LAST_CORNER = 2'd2;

	// Input transaction: one clip-space triangle.
	typedef struct packed {
		q16_t a_x;
		q16_t a_y;
		q16_t a_z;
		q16_t a_w;
		q16_t b_x;
		q16_t b_y;
		q16_t b_z;
		q16_t b_w;
		q16_t c_x;
		q16_t c_y;
		q16_t c_z;
		q16_t c_w;
	} tri_in_t;

	// Output transaction: one vertex of a surviving triangle.
	typedef struct packed {
		q16_t       out_x;
		q16_t       out_y;
		q16_t       out_z;
		q16_t       out_w;
		logic [1:0] corner;
		logic       last_vertex;
		logic       overflowed;
	} vert_out_t;

	// Front-end verdict on a triangle.
	typedef enum logic [1:0] {
		CLS_ACCEPT = 2'd0,
		CLS_REJECT = 2'd1,
		CLS_CLIP   = 2'd2
	} cls_t;

	// Queue entry between the front and the back.
	typedef struct packed {
		tri_t   corners;
		cls_t   cls;
		plane_t plane;
	} job_t;

	// Outcodes: bit j is set when corner j lies outside the plane.
	localparam code_t CODE_KEEP = 3'd0;
	localparam code_t CODE_OUT0 = 3'd1;
	localparam code_t CODE_OUT1 = 3'd2;
	localparam code_t CODE_IN2  = 3'd3;
	localparam code_t CODE_OUT2 = 3'd4;
	localparam code_t CODE_IN1  = 3'd5;
	localparam code_t CODE_IN0  = 3'd6;
	localparam code_t CODE_DROP = 3'd7;

	// Vertex sources when a triangle is written back.
	localparam src_t SRC_V0 = 3'd0;
	localparam src_t SRC_V1 = 3'd1;
	localparam src_t SRC_V2 = 3'd2;
	localparam src_t SRC_P  = 3'd3;
	localparam src_t SRC_Q  = 3'd4;

	// Outside and inside corner of one crossing edge.
	typedef struct packed {
		logic [1:0] o;
		logic [1:0] i;
	} ends_t;

	// Signed distance to a plane: negative means outside.
	function automatic dist_t plane_dist(vtx_t v, plane_t p);
		dist_t c;
		dist_t w;
		c = {v[p[2:1]][31], v[p[2:1]]};
		w = {v[3][31], v[3]};
		return p[0] ? (w + c) : (w - c);
	endfunction

	// Edge used for the first crossing (P) or the second (Q).
	function automatic ends_t cross_ends(code_t code, logic second);
		ends_t e;
		case (code)
			CODE_IN0: e = second ? '{o: 2'd2, i: 2'd0} : '{o: 2'd1, i: 2'd0};
			CODE_IN1: e = second ? '{o: 2'd0, i: 2'd1} : '{o: 2'd2, i: 2'd1};
			CODE_IN2: e = second ? '{o: 2'd1, i: 2'd2} : '{o: 2'd0, i: 2'd2};
			CODE_OUT2: e = second ? '{o: 2'd2, i: 2'd0} : '{o: 2'd2, i: 2'd1};
			CODE_OUT1: e = second ? '{o: 2'd1, i: 2'd2} : '{o: 2'd1, i: 2'd0};
			CODE_OUT0: e = second ? '{o: 2'd0, i: 2'd2} : '{o: 2'd0, i: 2'd1};
			default: e = '{o: 2'd0, i: 2'd0};
		endcase
		return e;
	endfunction

	// Source of corner j of the first or second written triangle.
	function automatic src_t tri_src(code_t code, logic second, logic [1:0] j);
		src_t s0;
		src_t s1;
		src_t s2;
		s0 = SRC_V0;
		s1 = SRC_V1;
		s2 = SRC_V2;
		case (code)
			CODE_IN0: begin
				s0 = SRC_V0; s1 = SRC_P; s2 = SRC_Q;
			end
			CODE_IN1: begin
				s0 = SRC_V1; s1 = SRC_P; s2 = SRC_Q;
			end
			CODE_IN2: begin
				s0 = SRC_V2; s1 = SRC_P; s2 = SRC_Q;
			end
			CODE_OUT2: begin
				s0 = SRC_V0;
				s1 = second ? SRC_P : SRC_V1;
				s2 = second ? SRC_Q : SRC_P;
			end
			CODE_OUT1: begin
				s0 = SRC_V2;
				s1 = second ? SRC_P : SRC_V0;
				s2 = second ? SRC_Q : SRC_P;
			end
			CODE_OUT0: begin
				s0 = SRC_V1;
				s1 = second ? SRC_Q : SRC_V2;
				s2 = second ? SRC_P : SRC_Q;
			end
			default: begin
				s0 = SRC_V0; s1 = SRC_V1; s2 = SRC_V2;
			end
		endcase
		case (j)
			2'd0: return s0;
			2'd1: return s1;
			default: return s2;
		endcase
	endfunction

	// True when one outside corner splits the triangle in two.
	function automatic logic is_split(code_t code);
		return (code == CODE_OUT0) || (code == CODE_OUT1) || (code == CODE_OUT2);
	endfunction

endpackage

### hdl/homogeneous_triangle_clipper_top.sv
// Homogeneous triangle clipper, top level.
// Depends on htc_pkg, htc_front, htc_fifo and htc_back.
//
// Input channel tri_valid / tri_stall / tri_data carries one clip-space triangle per
// transaction. Output channel vert_valid / vert_stall / vert_data carries one vertex
// of a surviving triangle per transaction, corners 0, 1, 2 in turn, last_vertex on
// corner 2 of the final triangle and overflowed on every vertex of a triangle whose
// clipping dropped triangles for capacity. A fully rejected triangle gives nothing.
// The front registers and classifies a triangle and hands it to a two-entry queue.
// A triangle inside all planes then goes from the queue straight to emission. Each
// crossing point in the back goes through the 17-step divider and then the one shared
// multiplier, component by component. The back works on one triangle at a time while
// the front keeps taking new ones until the queue is full.
// Reset clears all control state; the queue and output register come up empty.
// A stall on the output holds the registered vertex and pauses the emission.
`timescale 1ns / 1ps

module homogeneous_triangle_clipper_top import htc_pkg::*; #(
	parameter int MAX_TRIANGLES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tri_valid,
	output logic      tri_stall,
	input  tri_in_t   tri_data,
	output logic      vert_valid,
	input  logic      vert_stall,
	output vert_out_t vert_data
);
	job_t fe_job;
	job_t be_job;
	logic [$bits(job_t)-1:0] job_rd;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_valid;

	htc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.tri_data  (tri_data),
		.job_push  (job_push),
		.job       (fe_job),
		.job_full  (job_full)
	);

	htc_fifo #(
		.WIDTH ($bits(job_t))
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.wdata    (fe_job),
		.full     (job_full),
		.pop      (job_pop),
		.rdata    (job_rd),
		.nonempty (job_valid)
	);

	assign be_job = job_t'(job_rd);

	htc_back #(
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (be_job),
		.job_pop    (job_pop),
		.vert_valid (vert_valid),
		.vert_stall (vert_stall),
		.vert_data  (vert_data)
	);

endmodule

### hdl/htc_fifo.sv
// Two-entry queue that decouples the classifying front from the clipping back.
// Generic over the entry width; no package dependencies.
`timescale 1ns / 1ps

module htc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);
	localparam int DEPTH = 2;
	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;

	assign full = (cnt_q == NW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### hdl/htc_front.sv
// Front of the clipper: registers each triangle and classifies it against the six planes.
// Depends on htc_pkg; feeds the job queue.
`timescale 1ns / 1ps

module htc_front import htc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tri_valid,
	output logic    tri_stall,
	input  tri_in_t tri_data,
	output logic    job_push,
	output job_t    job,
	input  logic    job_full
);
	logic vld_s1;
	tri_t corners_s1;
	logic take;
	logic [PLANE_COUNT-1:0] all_in;
	logic [PLANE_COUNT-1:0] all_out;
	logic found;
	plane_t first_plane;

	assign tri_stall = vld_s1 && job_full;
	assign take = tri_valid && !tri_stall;
	assign job_push = vld_s1 && !job_full;

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (job_push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Input stage payload, one vertex per corner.
	always_ff @(posedge clk) begin
		if (take) begin
			corners_s1[0] <= {tri_data.a_w, tri_data.a_z, tri_data.a_y, tri_data.a_x};
			corners_s1[1] <= {tri_data.b_w, tri_data.b_z, tri_data.b_y, tri_data.b_x};
			corners_s1[2] <= {tri_data.c_w, tri_data.c_z, tri_data.c_y, tri_data.c_x};
		end
	end

	// Per-plane inside and outside summaries of the three corners.
	always_comb begin
		dist_t d0;
		dist_t d1;
		dist_t d2;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			d0 = plane_dist(corners_s1[0], plane_t'(p));
			d1 = plane_dist(corners_s1[1], plane_t'(p));
			d2 = plane_dist(corners_s1[2], plane_t'(p));
			all_out[p] = d0[32] & d1[32] & d2[32];
			all_in[p] = !(d0[32] | d1[32] | d2[32]);
		end
	end

	// The first plane that touches the triangle decides its class.
	always_comb begin
		found = 1'b0;
		first_plane = '0;
		for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
			if (!all_in[p]) begin
				found = 1'b1;
				first_plane = plane_t'(p);
			end
		end
		job.corners = corners_s1;
		job.plane = first_plane;
		if (!found) begin
			job.cls = CLS_ACCEPT;
		end else if (all_out[first_plane]) begin
			job.cls = CLS_REJECT;
		end else begin
			job.cls = CLS_CLIP;
		end
	end

endmodule

### hdl/htc_div.sv
// Restoring divider giving the edge parameter t as unsigned Q1.16, one bit a cycle.
// Depends on htc_pkg; used by the clipping back.
`timescale 1ns / 1ps

module htc_div import htc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dist_t           a,
	input  dist_t           b,
	output logic            done,
	output logic [T_FRAC:0] t
);
	localparam int RW = 36;

	logic busy_q;
	logic done_q;
	logic zero_q;
	logic full_q;
	logic [4:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [RW-1:0] trial;
	logic [T_FRAC:0] quo_q;
	logic signed [33:0] num;
	logic signed [33:0] den;
	logic ge;

	// Numerator -a and denominator b - a.
	assign num = -$signed({a[32], a});
	assign den = $signed({b[32], b}) - $signed({a[32], a});

	// The first step tests the integer bit, later steps shift the remainder.
	assign trial = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
	assign ge = (trial >= den_q);

	assign done = done_q;
	assign t = zero_q ? '0 : (full_q ? (T_FRAC + 1)'(1 << T_FRAC) : quo_q);

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(T_FRAC)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient. A non-positive denominator or a negative numerator gives zero;
	// a negative inside distance means the quotient exceeds one and is held at one.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, num};
			den_q <= {2'b00, den};
			quo_q <= '0;
			zero_q <= !((a <= 0) && (b > a));
			full_q <= b[32];
		end else if (busy_q) begin
			rem_q <= ge ? (trial - den_q) : trial;
			quo_q <= {quo_q[T_FRAC-1:0], ge};
		end
	end

endmodule

### hdl/htc_back.sv
// Back of the clipper: runs the plane passes over the triangle lists and emits vertices.
// Depends on htc_pkg and htc_div; takes jobs from the queue.
`timescale 1ns / 1ps

module htc_back import htc_pkg::*; #(
	parameter int MAX_TRIANGLES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      vert_valid,
	input  logic      vert_stall,
	output vert_out_t vert_data
);
	localparam int IW = $clog2(MAX_TRIANGLES);
	localparam int CW = $clog2(MAX_TRIANGLES + 1);
	localparam int ELIM = (MAX_TRIANGLES < EMIT_LIMIT) ? MAX_TRIANGLES : EMIT_LIMIT;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_FETCH = 10'b00_0000_0010,
		S_CLASS = 10'b00_0000_0100,
		S_SETUP = 10'b00_0000_1000,
		S_START = 10'b00_0001_0000,
		S_DIV   = 10'b00_0010_0000,
		S_MUL   = 10'b00_0100_0000,
		S_ADD   = 10'b00_1000_0000,
		S_PUSH  = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	tri_t list0_q [MAX_TRIANGLES];
	tri_t list1_q [MAX_TRIANGLES];
	logic cur_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] m_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] elim_q;
	plane_t plane_q;
	logic ovf_q;
	logic second_q;
	logic tsel_q;
	logic [1:0] k_q;
	logic [1:0] corner_q;
	tri_t tri_q;
	code_t code_q;
	vtx_t ov_q;
	vtx_t iv_q;
	vtx_t p_q;
	vtx_t q_q;
	logic signed [50:0] prod_s1;
	logic vert_valid_q;
	vert_out_t vert_data_q;

	tri_t rd_tri;
	logic [IW-1:0] rd_idx;
	dist_t d0;
	dist_t d1;
	dist_t d2;
	code_t code_now;
	ends_t ends;
	logic div_start;
	logic div_done;
	dist_t div_a;
	dist_t div_b;
	logic [T_FRAC:0] t_val;
	logic signed [32:0] diff;
	logic signed [51:0] rnd;
	logic signed [51:0] lerp_sum;
	logic [31:0] lerp_val;
	tri_t push_tri;
	logic push_ok;
	logic wr_en;
	logic wr_list;
	logic [IW-1:0] wr_idx;
	tri_t wr_tri;
	logic out_free;
	logic emit_fire;
	logic emit_last;

	// One read port on the current list, shared by fetch and emission.
	assign rd_idx = i_q[IW-1:0];
	assign rd_tri = cur_q ? list1_q[rd_idx] : list0_q[rd_idx];

	// Outcode of the fetched triangle for the current plane.
	assign d0 = plane_dist(tri_q[0], plane_q);
	assign d1 = plane_dist(tri_q[1], plane_q);
	assign d2 = plane_dist(tri_q[2], plane_q);
	assign code_now = {d2[32], d1[32], d0[32]};
	assign ends = cross_ends(code_q, second_q);

	// Edge parameter of the crossing.
	assign div_start = (state_q == S_START);
	assign div_a = plane_dist(ov_q, plane_q);
	assign div_b = plane_dist(iv_q, plane_q);

	htc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.t      (t_val)
	);

	// Interpolation of one component, rounding half upwards.
	assign diff = $signed({iv_q[k_q][31], iv_q[k_q]}) - $signed({ov_q[k_q][31], ov_q[k_q]});
	assign rnd = $signed({prod_s1[50], prod_s1}) + 52'sd32768;
	assign lerp_sum = $signed({{20{ov_q[k_q][31]}}, ov_q[k_q]}) + (rnd >>> T_FRAC);
	assign lerp_val = lerp_sum[31:0];

	// Triangle written by the push step.
	always_comb begin
		src_t s;
		for (int j = 0; j < 3; j++) begin
			s = tri_src(code_q, tsel_q, 2'(j));
			case (s)
				SRC_V0: push_tri[j] = tri_q[0];
				SRC_V1: push_tri[j] = tri_q[1];
				SRC_V2: push_tri[j] = tri_q[2];
				SRC_P: push_tri[j] = p_q;
				SRC_Q: push_tri[j] = q_q;
				default: push_tri[j] = tri_q[0];
			endcase
		end
	end

	assign push_ok = (m_q < CW'(MAX_TRIANGLES));
	assign job_pop = (state_q == S_IDLE) && job_valid;

	// List write port: the incoming triangle, or a triangle of the next list.
	always_comb begin
		if (state_q == S_PUSH) begin
			wr_en = push_ok;
			wr_list = ~cur_q;
			wr_idx = m_q[IW-1:0];
			wr_tri = push_tri;
		end else begin
			wr_en = job_pop;
			wr_list = 1'b0;
			wr_idx = '0;
			wr_tri = job.corners;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_list) begin
				list1_q[wr_idx] <= wr_tri;
			end else begin
				list0_q[wr_idx] <= wr_tri;
			end
		end
	end

	// Output register handshake.
	assign out_free = !vert_valid_q || !vert_stall;
	assign emit_fire = (state_q == S_EMIT) && out_free;
	assign emit_last = ((i_q + CW'(1)) == elim_q) && (corner_q == LAST_CORNER);
	assign vert_valid = vert_valid_q;
	assign vert_data = vert_data_q;

	// Sequencer for the plane passes and the emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= 1'b0;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			elim_q <= '0;
			plane_q <= '0;
			ovf_q <= 1'b0;
			second_q <= 1'b0;
			tsel_q <= 1'b0;
			k_q <= '0;
			corner_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						cur_q <= 1'b0;
						n_q <= CW'(1);
						m_q <= '0;
						i_q <= '0;
						corner_q <= '0;
						ovf_q <= 1'b0;
						elim_q <= CW'(1);
						plane_q <= job.plane;
						case (job.cls)
							CLS_ACCEPT: state_q <= S_EMIT;
							CLS_CLIP: state_q <= S_FETCH;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_FETCH: begin
					if (i_q == n_q) begin
						// End of a pass: the next list becomes current.
						n_q <= m_q;
						m_q <= '0;
						i_q <= '0;
						cur_q <= ~cur_q;
						if (m_q == '0) begin
							state_q <= S_IDLE;
						end else if (plane_q == PLANE_LAST) begin
							state_q <= S_EMIT;
							if (int'(m_q) > ELIM) begin
								elim_q <= CW'(ELIM);
								ovf_q <= 1'b1;
							end else begin
								elim_q <= m_q;
							end
						end else begin
							plane_q <= plane_q + 3'd1;
						end
					end else begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					case (code_now)
						CODE_KEEP: begin
							tsel_q <= 1'b0;
							state_q <= S_PUSH;
						end
						CODE_DROP: begin
							i_q <= i_q + CW'(1);
							state_q <= S_FETCH;
						end
						default: begin
							second_q <= 1'b0;
							state_q <= S_SETUP;
						end
					endcase
				end
				S_SETUP: state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						k_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'(VTX_COMPONENTS - 1)) begin
						if (!second_q) begin
							second_q <= 1'b1;
							state_q <= S_SETUP;
						end else begin
							tsel_q <= 1'b0;
							state_q <= S_PUSH;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_PUSH: begin
					if (push_ok) begin
						m_q <= m_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (is_split(code_q) && !tsel_q) begin
						tsel_q <= 1'b1;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_FETCH;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (corner_q == LAST_CORNER) begin
							corner_q <= '0;
							i_q <= i_q + CW'(1);
							if (emit_last) begin
								state_q <= S_IDLE;
							end
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_valid_q <= 1'b0;
		end else if (emit_fire) begin
			vert_valid_q <= 1'b1;
		end else if (!vert_stall) begin
			vert_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_FETCH) && (i_q != n_q)) begin
			tri_q <= rd_tri;
		end
		if (state_q == S_CLASS) begin
			code_q <= code_now;
		end
		if (state_q == S_SETUP) begin
			ov_q <= tri_q[ends.o];
			iv_q <= tri_q[ends.i];
		end
		if (state_q == S_MUL) begin
			prod_s1 <= diff * $signed({1'b0, t_val});
		end
		if (state_q == S_ADD) begin
			if (second_q) begin
				q_q[k_q] <= lerp_val;
			end else begin
				p_q[k_q] <= lerp_val;
			end
		end
		if (emit_fire) begin
			vert_data_q.out_x <= $signed(rd_tri[corner_q][0]);
			vert_data_q.out_y <= $signed(rd_tri[corner_q][1]);
			vert_data_q.out_z <= $signed(rd_tri[corner_q][2]);
			vert_data_q.out_w <= $signed(rd_tri[corner_q][3]);
			vert_data_q.corner <= corner_q;
			vert_data_q.last_vertex <= emit_last;
			vert_data_q.overflowed <= ovf_q;
		end
	end

`ifndef SYNTHESIS
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_q <= CW'(MAX_TRIANGLES)) && (n_q <= CW'(MAX_TRIANGLES)))
		else $error("triangle list count beyond capacity");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");
	a_plane: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q <= PLANE_LAST)
		else $error("plane index out of range");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> ((i_q < elim_q) && (corner_q <= LAST_CORNER)))
		else $error("emission beyond the surviving triangles");
`endif

endmodule
